/* sv/png_chunk_deframer_core_defines.svh */
// assertion macros shared by the png chunk deframer rtl
// no dependencies; included by the files that carry assertions
`ifndef PNG_CHUNK_DEFRAMER_CORE_DEFINES_SVH
`define PNG_CHUNK_DEFRAMER_CORE_DEFINES_SVH

// checked while out of reset
`define PCD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pcd assertion failed");

// checked on every edge, reset included
`define PCD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("pcd assertion failed");

`endif

/* sv/pcd_pkg.sv */
// types, codes and lookup functions for the png chunk deframer
// no dependencies; used by pcd_walker, pcd_rsp_reg and the top level
package pcd_pkg;

   localparam int unsigned LenW    = 31;
   localparam int unsigned CntW    = 31;
   localparam logic [7:0]  MaxChunksReset = 8'd10;

   typedef enum logic [2:0] {
      PH_SIG,
      PH_LEN,
      PH_TYPE,
      PH_DATA,
      PH_CRC,
      PH_IDLE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_DATA    = 2'd1,
      KIND_BAD_SIG = 2'd2,
      KIND_BAD_LEN = 2'd3
   } kind_type;

   localparam logic [4:0] CLS_IHDR      = 5'd0;
   localparam logic [4:0] CLS_IDAT      = 5'd1;
   localparam logic [4:0] CLS_IEND      = 5'd2;
   localparam logic [4:0] CLS_TRNS      = 5'd3;
   localparam logic [4:0] CLS_TIME      = 5'd4;
   localparam logic [4:0] CLS_GAMA      = 5'd5;
   localparam logic [4:0] CLS_CHRM      = 5'd6;
   localparam logic [4:0] CLS_SBIT      = 5'd7;
   localparam logic [4:0] CLS_SPLT      = 5'd8;
   localparam logic [4:0] CLS_SRGB      = 5'd9;
   localparam logic [4:0] CLS_ICCP      = 5'd10;
   localparam logic [4:0] CLS_ITXT      = 5'd11;
   localparam logic [4:0] CLS_TEXT      = 5'd12;
   localparam logic [4:0] CLS_ZTXT      = 5'd13;
   localparam logic [4:0] CLS_BKGD      = 5'd14;
   localparam logic [4:0] CLS_PHYS      = 5'd15;
   localparam logic [4:0] CLS_HIST      = 5'd16;
   localparam logic [4:0] CLS_UNKNOWN   = 5'd17;
   localparam logic [4:0] CLS_UNMATCHED = 5'd18;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [LenW-1:0]   chunk_length;
      logic [4:0]        type_class;
      logic              critical;
      logic              public_name;
      logic              conforming;
      logic              unsafe_copy;
      logic              last_chunk;
      logic [7:0]        out_byte;
   } result_type;

   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'h89;
         3'd1:    b = 8'h50;
         3'd2:    b = 8'h4E;
         3'd3:    b = 8'h47;
         3'd4:    b = 8'h0D;
         3'd5:    b = 8'h0A;
         3'd6:    b = 8'h1A;
         3'd7:    b = 8'h0A;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // letter tests: last byte and first byte decide, second byte breaks ties
   function automatic logic [4:0] classify(input logic [7:0] t0, input logic [7:0] t1,
                                           input logic [7:0] t3);
      logic [4:0] c;
      c = CLS_UNMATCHED;
      if (t3 == "T") begin
         case (t0)
            "I":     c = CLS_IDAT;
            "s":     c = (t1 == "B") ? CLS_SBIT : ((t1 == "P") ? CLS_SPLT : CLS_UNMATCHED);
            "h":     c = CLS_HIST;
            default: c = CLS_UNMATCHED;
         endcase
      end else if (t3 == "t") begin
         case (t0)
            "i":     c = CLS_ITXT;
            "t":     c = CLS_TEXT;
            "z":     c = CLS_ZTXT;
            default: c = CLS_UNMATCHED;
         endcase
      end else if (t0 == "I") begin
         c = (t1 == "H") ? CLS_IHDR : ((t1 == "E") ? CLS_IEND : CLS_UNMATCHED);
      end else if (t0 == "t") begin
         c = (t1 == "R") ? CLS_TRNS : ((t1 == "I") ? CLS_TIME : CLS_UNMATCHED);
      end else begin
         case (t0)
            "g":     c = CLS_GAMA;
            "b":     c = CLS_BKGD;
            "c":     c = CLS_CHRM;
            "i":     c = CLS_ICCP;
            "p":     c = CLS_PHYS;
            "U":     c = CLS_UNKNOWN;
            "s":     c = CLS_SRGB;
            default: c = CLS_UNMATCHED;
         endcase
      end
      return c;
   endfunction

endpackage

/* sv/pcd_walker.sv */
// chunk walker: phase state machine, counters, length and type capture
// depends on pcd_pkg and png_chunk_deframer_core_defines.svh
`include "png_chunk_deframer_core_defines.svh"

module pcd_walker (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [7:0]         in_byte,
   input  logic               file_start,
   input  logic               csr_wr_en,
   input  logic [7:0]         csr_wr_data,
   output pcd_pkg::result_type res
);

   pcd_pkg::phase_type          phase_ff, phase_in, cur_phase;
   logic [pcd_pkg::CntW-1:0]    cnt_ff, cnt_in, cur_cnt, cnt_inc;
   logic [31:0]                 length_ff, length_in, len_shift;
   logic [7:0]                  type_ff [0:2];
   logic [7:0]                  type_in [0:2];
   logic [7:0]                  chunks_ff, chunks_in, cur_chunks, chunks_inc;
   logic [7:0]                  max_chunks_ff, max_chunks_in, lim;
   logic                        sig_ok, sig_end, quad_end, data_end, hdr_last, crc_stop;

   // a file_start beat restarts the parse before the byte is looked at
   assign cur_phase  = file_start ? pcd_pkg::PH_SIG : phase_ff;
   assign cur_cnt    = file_start ? '0 : cnt_ff;
   assign cur_chunks = file_start ? 8'd0 : chunks_ff;

   assign cnt_inc    = cur_cnt + 1'b1;
   assign len_shift  = {length_ff[23:0], in_byte};
   assign chunks_inc = (cur_chunks == 8'hFF) ? cur_chunks : cur_chunks + 8'd1;
   assign lim        = (max_chunks_ff == 8'd0) ? 8'd1 : max_chunks_ff;
   assign hdr_last   = (length_ff == 32'd0) || (chunks_inc >= lim);
   assign crc_stop   = (cur_chunks >= lim);
   assign sig_ok     = (in_byte == pcd_pkg::sig_byte(cur_cnt[2:0]));
   assign sig_end    = (cur_cnt[2:0] == 3'd7);
   assign quad_end   = (cur_cnt[1:0] == 2'd3);
   assign data_end   = (cnt_inc == length_ff[pcd_pkg::LenW-1:0]);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         case (cur_phase)
            pcd_pkg::PH_SIG: begin
               if (!sig_ok) phase_in = pcd_pkg::PH_IDLE;
               else if (sig_end) phase_in = pcd_pkg::PH_LEN;
               else phase_in = pcd_pkg::PH_SIG;
            end
            pcd_pkg::PH_LEN: begin
               if (!quad_end) phase_in = pcd_pkg::PH_LEN;
               else if (len_shift[31]) phase_in = pcd_pkg::PH_IDLE;
               else phase_in = pcd_pkg::PH_TYPE;
            end
            pcd_pkg::PH_TYPE: begin
               if (!quad_end) phase_in = pcd_pkg::PH_TYPE;
               else if (length_ff == 32'd0) phase_in = pcd_pkg::PH_IDLE;
               else phase_in = pcd_pkg::PH_DATA;
            end
            pcd_pkg::PH_DATA: begin
               phase_in = data_end ? pcd_pkg::PH_CRC : pcd_pkg::PH_DATA;
            end
            pcd_pkg::PH_CRC: begin
               if (!quad_end) phase_in = pcd_pkg::PH_CRC;
               else if (crc_stop) phase_in = pcd_pkg::PH_IDLE;
               else phase_in = pcd_pkg::PH_LEN;
            end
            default: phase_in = pcd_pkg::PH_IDLE;
         endcase
      end
   end

   // counters, captured bytes and the result of this beat
   always_comb begin
      cnt_in        = cnt_ff;
      length_in     = length_ff;
      chunks_in     = chunks_ff;
      max_chunks_in = csr_wr_en ? csr_wr_data : max_chunks_ff;
      for (int i = 0; i < 3; i++) begin
         type_in[i] = type_ff[i];
      end
      res = '0;
      if (take) begin
         // count restarts on every phase change
         cnt_in    = (phase_in != cur_phase) ? '0 : cnt_inc;
         chunks_in = cur_chunks;
         case (cur_phase)
            pcd_pkg::PH_SIG: begin
               if (!sig_ok) begin
                  res.valid = 1'b1;
                  res.kind  = pcd_pkg::KIND_BAD_SIG;
               end
            end
            pcd_pkg::PH_LEN: begin
               length_in = len_shift;
               if (quad_end && len_shift[31]) begin
                  res.valid = 1'b1;
                  res.kind  = pcd_pkg::KIND_BAD_LEN;
               end
            end
            pcd_pkg::PH_TYPE: begin
               for (int i = 0; i < 3; i++) begin
                  if (cur_cnt[1:0] == 2'(i)) type_in[i] = in_byte;
               end
               if (quad_end) begin
                  chunks_in        = chunks_inc;
                  res.valid        = 1'b1;
                  res.kind         = pcd_pkg::KIND_HEADER;
                  res.chunk_length = length_ff[pcd_pkg::LenW-1:0];
                  res.type_class   = pcd_pkg::classify(type_ff[0], type_ff[1], in_byte);
                  res.critical     = ~type_ff[0][5];
                  res.public_name  = ~type_ff[1][5];
                  res.conforming   = ~type_ff[2][5];
                  res.unsafe_copy  = ~in_byte[5];
                  res.last_chunk   = hdr_last;
               end
            end
            pcd_pkg::PH_DATA: begin
               res.valid    = 1'b1;
               res.kind     = pcd_pkg::KIND_DATA;
               res.out_byte = in_byte;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= pcd_pkg::PH_SIG;
         cnt_ff        <= '0;
         chunks_ff     <= 8'd0;
         max_chunks_ff <= pcd_pkg::MaxChunksReset;
      end else begin
         phase_ff      <= phase_in;
         cnt_ff        <= cnt_in;
         chunks_ff     <= chunks_in;
         max_chunks_ff <= max_chunks_in;
      end
   end

   always_ff @(posedge clock) begin
      length_ff <= length_in;
      for (int i = 0; i < 3; i++) begin
         type_ff[i] <= type_in[i];
      end
   end

   `PCD_ASSERT_ALWAYS(a_reset_sig, clock, reset |=> (phase_ff == pcd_pkg::PH_SIG && chunks_ff == 8'd0))
   `PCD_ASSERT(a_data_in_range, clock, reset, (phase_ff == pcd_pkg::PH_DATA) |-> (cnt_ff < length_ff[pcd_pkg::LenW-1:0]))
   `PCD_ASSERT(a_type_len_ok, clock, reset, (phase_ff == pcd_pkg::PH_TYPE) |-> !length_ff[31])
   `PCD_ASSERT(a_hdr_then_data, clock, reset, (take && cur_phase == pcd_pkg::PH_TYPE && quad_end) |=> ((phase_ff == pcd_pkg::PH_DATA || phase_ff == pcd_pkg::PH_IDLE) && cnt_ff == '0))

endmodule

/* sv/pcd_rsp_reg.sv */
// result register between the walker and the rsp channel
// depends on pcd_pkg
module pcd_rsp_reg (
   input  logic               clock,
   input  logic               reset,
   input  pcd_pkg::result_type res,
   input  logic               rsp_stall,
   output logic               hold,
   output logic               rsp_valid,
   output pcd_pkg::result_type rsp_data
);

   logic                valid_ff, valid_in, load;
   pcd_pkg::result_type data_ff, data_in;

   // register takes a new beat when empty or being drained
   assign load     = !valid_ff || !rsp_stall;
   assign hold     = !load;
   assign valid_in = load ? res.valid : valid_ff;
   assign data_in  = (load && res.valid) ? res : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

/* sv/png_chunk_deframer_core.sv */
// png chunk deframer, one file byte per req beat
// byte stream in on req_*, chunk headers and data bytes out on rsp_*, one
// eight-bit register (max_chunks) written on csr_*.
// a beat with req_file_start high restarts the walk at signature byte 0.
// signature bytes, length, type and crc bytes give no rsp beat except for a
// bad signature or a length with bit 31 set; the fourth type byte gives a
// header beat and each data byte gives a data beat.
// a result is registered and appears on rsp in the cycle after its req beat is taken.
// throughput: one req beat per cycle while req_stall is low; the limit is the single result
// register, which holds one beat.
// when rsp_stall is high with a beat waiting, req_stall rises in the same
// cycle and no byte is taken until that beat leaves.
// after the walk ends (zero length, chunk limit or error) bytes are dropped
// silently until the next req_file_start.
// reset: sync, active high; walk returns to the signature, max_chunks to 10,
// rsp side empty.
// depends on pcd_pkg, pcd_walker, pcd_rsp_reg
module png_chunk_deframer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_file_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [30:0] rsp_chunk_length,
   output logic [4:0]  rsp_type_class,
   output logic        rsp_critical,
   output logic        rsp_public_name,
   output logic        rsp_conforming,
   output logic        rsp_unsafe_copy,
   output logic        rsp_last_chunk,
   output logic [7:0]  rsp_out_byte,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   pcd_pkg::result_type res, rsp_data;
   logic                take, hold;

   assign req_stall = hold;
   assign take      = req_valid && !hold;

   pcd_walker u_walker (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .in_byte     (req_in_byte),
      .file_start  (req_file_start),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .res         (res)
   );

   pcd_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .res       (res),
      .rsp_stall (rsp_stall),
      .hold      (hold),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind         = rsp_data.kind;
   assign rsp_chunk_length = rsp_data.chunk_length;
   assign rsp_type_class   = rsp_data.type_class;
   assign rsp_critical     = rsp_data.critical;
   assign rsp_public_name  = rsp_data.public_name;
   assign rsp_conforming   = rsp_data.conforming;
   assign rsp_unsafe_copy  = rsp_data.unsafe_copy;
   assign rsp_last_chunk   = rsp_data.last_chunk;
   assign rsp_out_byte     = rsp_data.out_byte;

endmodule

/* tb/sv/png_chunk_deframer_core_tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for png_chunk_deframer_core: feeds png byte streams with
// random idle and stall, predicts every rsp beat and compares it field by field
// depends on pcd_pkg and the png_chunk_deframer_core rtl
module png_chunk_deframer_core_tb;

   localparam int IdleLimit   = 2000;
   localparam int DrainCycles = 3;
   localparam logic [63:0] PngMagic = 64'h8950_4E47_0D0A_1A0A;
   localparam int NumTags = 24;
   // every class name plus near misses that fall through the letter tests
   localparam logic [NumTags*32-1:0] KnownTags = {
      "IHDR", "IDAT", "IEND", "tRNS", "tIME", "gAMA", "cHRM", "sBIT",
      "sPLT", "sRGB", "iCCP", "iTXt", "tEXt", "zTXt", "bKGD", "pHYs",
      "hIST", "Uabc", "abcd", "sQAT", "IQDR", "tQNS", "qrst", "eXIf"};

   typedef struct packed {
      pcd_pkg::kind_type kind;
      logic [30:0] chunk_length;
      logic [4:0]  type_class;
      logic        critical;
      logic        public_name;
      logic        conforming;
      logic        unsafe_copy;
      logic        last_chunk;
      logic [7:0]  out_byte;
   } deframe_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        req_file_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [30:0] rsp_chunk_length;
   logic [4:0]  rsp_type_class;
   logic        rsp_critical;
   logic        rsp_public_name;
   logic        rsp_conforming;
   logic        rsp_unsafe_copy;
   logic        rsp_last_chunk;
   logic [7:0]  rsp_out_byte;
   logic        csr_wr_en = 1'b0;
   logic [7:0]  csr_wr_data = 8'h00;

   // predictor state
   pcd_pkg::phase_type walk_phase = pcd_pkg::PH_SIG;
   logic [31:0] walk_count = '0;
   logic [31:0] walk_length = '0;
   logic [31:0] walk_tag = '0;
   logic [7:0]  walk_chunks = '0;
   logic [7:0]  max_chunks_cfg = 8'd10;

   deframe_beat_type expected_beats[$];
   logic [7:0]    file_bytes[$];
   int            fail_count = 0;
   int            live_bytes = 0;
   int            quiet_cycles = 0;
   int            stall_left = 0;
   bit            tx_quiet = 1'b0;
   bit            rx_quiet = 1'b0;

   png_chunk_deframer_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_file_start  (req_file_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_chunk_length(rsp_chunk_length),
      .rsp_type_class  (rsp_type_class),
      .rsp_critical    (rsp_critical),
      .rsp_public_name (rsp_public_name),
      .rsp_conforming  (rsp_conforming),
      .rsp_unsafe_copy (rsp_unsafe_copy),
      .rsp_last_chunk  (rsp_last_chunk),
      .rsp_out_byte    (rsp_out_byte),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap(input bit quiet);
      int roll;
      roll = $urandom_range(99);
      if (quiet || roll < 60) return 0;
      if (roll < 93) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // type byte 0 sits in tag[31:24]
   function automatic logic [4:0] class_of_tag(input logic [31:0] tag);
      logic [7:0] b0, b1, b3;
      logic [4:0] cls;
      b0 = tag[31:24];
      b1 = tag[23:16];
      b3 = tag[7:0];
      cls = pcd_pkg::CLS_UNMATCHED;
      if (b3 == "T") begin
         if (b0 == "I") cls = pcd_pkg::CLS_IDAT;
         else if (b0 == "h") cls = pcd_pkg::CLS_HIST;
         else if (b0 == "s" && b1 == "B") cls = pcd_pkg::CLS_SBIT;
         else if (b0 == "s" && b1 == "P") cls = pcd_pkg::CLS_SPLT;
      end else if (b3 == "t") begin
         if (b0 == "i") cls = pcd_pkg::CLS_ITXT;
         else if (b0 == "t") cls = pcd_pkg::CLS_TEXT;
         else if (b0 == "z") cls = pcd_pkg::CLS_ZTXT;
      end else begin
         case (b0)
            "I": begin
               if (b1 == "H") cls = pcd_pkg::CLS_IHDR;
               else if (b1 == "E") cls = pcd_pkg::CLS_IEND;
            end
            "t": begin
               if (b1 == "R") cls = pcd_pkg::CLS_TRNS;
               else if (b1 == "I") cls = pcd_pkg::CLS_TIME;
            end
            "g": cls = pcd_pkg::CLS_GAMA;
            "b": cls = pcd_pkg::CLS_BKGD;
            "c": cls = pcd_pkg::CLS_CHRM;
            "i": cls = pcd_pkg::CLS_ICCP;
            "p": cls = pcd_pkg::CLS_PHYS;
            "U": cls = pcd_pkg::CLS_UNKNOWN;
            "s": cls = pcd_pkg::CLS_SRGB;
            default: cls = pcd_pkg::CLS_UNMATCHED;
         endcase
      end
      return cls;
   endfunction

   // advances the walk by one byte; returns 1 when the byte yields a beat
   function automatic bit walk_byte(input logic [7:0] b, input logic start,
                                    output deframe_beat_type beat);
      logic [7:0] limit;
      bit         produced;
      beat = '0;
      produced = 1'b0;
      if (start) begin
         walk_phase = pcd_pkg::PH_SIG;
         walk_count = '0;
         walk_length = '0;
         walk_tag = '0;
         walk_chunks = '0;
      end
      limit = (max_chunks_cfg == 8'd0) ? 8'd1 : max_chunks_cfg;
      case (walk_phase)
         pcd_pkg::PH_SIG: begin
            if (b != PngMagic[63 - 8*walk_count[2:0] -: 8]) begin
               walk_phase = pcd_pkg::PH_IDLE;
               beat.kind = pcd_pkg::KIND_BAD_SIG;
               produced = 1'b1;
            end else begin
               walk_count++;
               if (walk_count >= 8) begin
                  walk_phase = pcd_pkg::PH_LEN;
                  walk_count = '0;
                  walk_length = '0;
               end
            end
         end
         pcd_pkg::PH_LEN: begin
            walk_length = {walk_length[23:0], b};
            walk_count++;
            if (walk_count >= 4) begin
               walk_count = '0;
               if (walk_length[31]) begin
                  walk_phase = pcd_pkg::PH_IDLE;
                  beat.kind = pcd_pkg::KIND_BAD_LEN;
                  produced = 1'b1;
               end else begin
                  walk_phase = pcd_pkg::PH_TYPE;
               end
            end
         end
         pcd_pkg::PH_TYPE: begin
            walk_tag[31 - 8*walk_count[1:0] -: 8] = b;
            walk_count++;
            if (walk_count >= 4) begin
               walk_count = '0;
               if (walk_chunks != 8'd255) walk_chunks++;
               beat.kind = pcd_pkg::KIND_HEADER;
               beat.chunk_length = walk_length[30:0];
               beat.type_class = class_of_tag(walk_tag);
               // upper case letters have bit 5 clear
               beat.critical = ~walk_tag[29];
               beat.public_name = ~walk_tag[21];
               beat.conforming = ~walk_tag[13];
               beat.unsafe_copy = ~walk_tag[5];
               beat.last_chunk = (walk_length == 0) || (walk_chunks >= limit);
               walk_phase = (walk_length == 0) ? pcd_pkg::PH_IDLE : pcd_pkg::PH_DATA;
               produced = 1'b1;
            end
         end
         pcd_pkg::PH_DATA: begin
            beat.kind = pcd_pkg::KIND_DATA;
            beat.out_byte = b;
            produced = 1'b1;
            walk_count++;
            if (walk_count >= walk_length) begin
               walk_count = '0;
               walk_phase = pcd_pkg::PH_CRC;
            end
         end
         pcd_pkg::PH_CRC: begin
            walk_count++;
            if (walk_count >= 4) begin
               walk_count = '0;
               walk_length = '0;
               walk_phase = (walk_chunks >= limit) ? pcd_pkg::PH_IDLE : pcd_pkg::PH_LEN;
            end
         end
         default: walk_phase = pcd_pkg::PH_IDLE;
      endcase
      return produced;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic start);
      int               gap;
      deframe_beat_type beat;
      gap = pick_gap(tx_quiet);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_file_start <= start;
      do @(posedge clock); while (req_stall);
      if (start || walk_phase != pcd_pkg::PH_IDLE) live_bytes++;
      if (walk_byte(b, start, beat)) expected_beats.push_back(beat);
   endtask

   task automatic send_stream();
      for (int i = 0; i < file_bytes.size(); i++) send_byte(file_bytes[i], i == 0);
      file_bytes.delete();
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic set_max_chunks(input logic [7:0] value);
      wait_for_drain();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      max_chunks_cfg = value;
   endtask

   task automatic push_word(input logic [31:0] w);
      for (int i = 3; i >= 0; i--) file_bytes.push_back(w[8*i +: 8]);
   endtask

   task automatic push_signature();
      push_word(PngMagic[63:32]);
      push_word(PngMagic[31:0]);
   endtask

   // crc follows only when the whole data part is pushed
   task automatic push_chunk(input logic [31:0] len, input logic [31:0] tag,
                             input int ndata);
      push_word(len);
      push_word(tag);
      repeat (ndata) file_bytes.push_back(8'($urandom));
      if (ndata == len) push_word($urandom);
   endtask

   function automatic logic [31:0] pick_tag();
      logic [31:0] tag;
      if ($urandom_range(99) < 25) return $urandom;
      tag = KnownTags[32*$urandom_range(NumTags-1) +: 32];
      // flip the case of one letter now and then
      if ($urandom_range(99) < 20) tag[8*$urandom_range(3) + 5] ^= 1'b1;
      return tag;
   endfunction

   task automatic send_random_file();
      int          chunks, style, roll;
      logic [31:0] len;
      chunks = $urandom_range(10, 1);
      style = $urandom_range(99);
      push_signature();
      if (style < 10) file_bytes[$urandom_range(7)] ^= 8'($urandom_range(255, 1));
      for (int c = 0; c < chunks; c++) begin
         if (c == chunks - 1 && style >= 10 && style < 18) begin
            push_word({1'b1, 31'($urandom)});
            push_word(pick_tag());
         end else if (c == chunks - 1 && style >= 18 && style < 26) begin
            // huge length, the file is cut off inside the data
            push_chunk({1'b0, 31'($urandom)}, pick_tag(), $urandom_range(6));
         end else if (c == chunks - 1 && $urandom_range(1)) begin
            push_chunk(0, "IEND", 0);
         end else begin
            roll = $urandom_range(99);
            if (roll < 4) len = 0;
            else if (roll < 65) len = $urandom_range(8, 1);
            else if (roll < 92) len = $urandom_range(32, 9);
            else len = $urandom_range(150, 33);
            push_chunk(len, pick_tag(), len);
         end
      end
      // trailing noise lands on an idle walk or on a running chunk
      repeat ($urandom_range(3)) file_bytes.push_back(8'($urandom));
      if ($urandom_range(99) < 5) wait_for_drain();
      send_stream();
   endtask

   task automatic test_bad_signature();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      push_signature();
      file_bytes[7] = 8'h0B;
      send_stream();
   endtask

   task automatic test_length_extremes();
      push_signature();
      push_word(32'h7FFF_FFFF);
      push_word("IHDR");
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'hFF);
      send_stream();
      push_signature();
      push_word(32'hFFFF_FFFF);
      send_stream();
      push_signature();
      push_chunk(0, "iend", 0);
      file_bytes.push_back(8'h89);
      send_stream();
   endtask

   task automatic test_chunk_limit();
      set_max_chunks(8'd0);
      push_signature();
      push_chunk(2, "tEXt", 2);
      push_chunk(1, "IDAT", 1);
      send_stream();
   endtask

   task automatic test_chunk_ceiling();
      set_max_chunks(8'd255);
      tx_quiet = 1'b1;
      rx_quiet = 1'b1;
      push_signature();
      repeat (20) push_chunk(1, pick_tag(), 1);
      send_stream();
   endtask

   task automatic test_random_streams();
      logic [7:0] setting;
      for (int p = 0; p < 7; p++) begin
         case (p)
            0: setting = 8'd255;
            1: setting = 8'd1;
            2: setting = 8'd3;
            3: setting = 8'd0;
            4: setting = 8'd2;
            default: setting = 8'($urandom_range(255));
         endcase
         set_max_chunks(setting);
         tx_quiet = (p == 2 || p == 5);
         rx_quiet = (p == 2 || p == 4);
         live_bytes = 0;
         while (live_bytes < 120) send_random_file();
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", field, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      deframe_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            $error("rsp beat with nothing expected, kind %0d", rsp_kind);
            fail_count++;
         end else begin
            want = expected_beats.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_kind));
            check_field("chunk_length", 32'(want.chunk_length), 32'(rsp_chunk_length));
            check_field("type_class", 32'(want.type_class), 32'(rsp_type_class));
            check_field("critical", 32'(want.critical), 32'(rsp_critical));
            check_field("public_name", 32'(want.public_name), 32'(rsp_public_name));
            check_field("conforming", 32'(want.conforming), 32'(rsp_conforming));
            check_field("unsafe_copy", 32'(want.unsafe_copy), 32'(rsp_unsafe_copy));
            check_field("last_chunk", 32'(want.last_chunk), 32'(rsp_last_chunk));
            check_field("out_byte", 32'(want.out_byte), 32'(rsp_out_byte));
         end
      end
   end

   always @(negedge clock) begin : rsp_backpressure
      int hold;
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         hold = pick_gap(rx_quiet);
         stall_left = (hold > 0) ? hold - 1 : 0;
         rsp_stall <= (hold > 0);
      end
   end

   // ends a hung run: no beat moved on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
         $display("png_chunk_deframer_core: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_bad_signature();
      test_length_extremes();
      test_chunk_limit();
      test_random_streams();
      test_chunk_ceiling();
      wait_for_drain();
      if (fail_count == 0) $display("png_chunk_deframer_core: match");
      else $display("png_chunk_deframer_core: mismatch");
      $finish;
   end

endmodule

/* sim.f */
+incdir+sv
sv/pcd_pkg.sv
sv/pcd_walker.sv
sv/pcd_rsp_reg.sv
sv/png_chunk_deframer_core.sv
tb/sv/png_chunk_deframer_core_tb.sv
